/* design/pls_pkg.sv */
// shared types, select codes and state encoding for the polygon line splitter
// used by pls_datapath, pls_ctrl and the top level
package pls_pkg;

   localparam int COORD_WIDTH_DEF = 32;
   localparam int CSR_ADDR_W      = 2;

   // configuration register indexes
   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_LINE_AX = 2'd0,
      CSR_LINE_AY = 2'd1,
      CSR_LINE_BX = 2'd2,
      CSR_LINE_BY = 2'd3
   } csr_idx_type;

   // wide multiplicand select
   typedef enum logic [2:0] {
      A_ABX = 3'd0,
      A_ABY = 3'd1,
      A_DDY = 3'd2,
      A_T   = 3'd3,
      A_U   = 3'd4
   } a_sel_type;

   // narrow multiplier select
   typedef enum logic [3:0] {
      B_VY_AY = 4'd0,
      B_VX_AX = 4'd1,
      B_AX_CX = 4'd2,
      B_AX    = 4'd3,
      B_AY    = 4'd4,
      B_CY    = 4'd5,
      B_ABX   = 4'd6,
      B_DDX   = 4'd7,
      B_CX    = 4'd8,
      B_X_AX  = 4'd9
   } b_sel_type;

   // divisor select
   typedef enum logic [1:0] {
      D_DDX = 2'd0,
      D_M   = 2'd1,
      D_ABX = 2'd2
   } d_sel_type;

   // term added to the quotient
   typedef enum logic [1:0] {
      P_ZERO = 2'd0,
      P_CY   = 2'd1,
      P_AY   = 2'd2
   } p_sel_type;

   typedef enum logic [1:0] {
      XR_HOLD = 2'd0,
      XR_AX   = 2'd1,
      XR_CX   = 2'd2,
      XR_DIV  = 2'd3
   } xr_sel_type;

   typedef enum logic [1:0] {
      YR_HOLD = 2'd0,
      YR_CY   = 2'd1,
      YR_DIV  = 2'd2
   } yr_sel_type;

   typedef enum logic [1:0] {
      OK_UPPER  = 2'd0,
      OK_LOWER  = 2'd1,
      OK_VERTEX = 2'd2
   } out_kind_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_SIDE_A,
      ST_SIDE_B,
      ST_DECIDE,
      ST_V_MUL,
      ST_V_DIV,
      ST_P0,
      ST_P1,
      ST_P2,
      ST_U,
      ST_M0,
      ST_M1,
      ST_N0,
      ST_N1,
      ST_X_DIV,
      ST_Y_MUL,
      ST_Y_DIV,
      ST_EMIT_U,
      ST_EMIT_L,
      ST_EMIT_V
   } state_type;

   typedef struct packed {
      logic         ld_in;
      logic         mul_start;
      logic         mul_clear;
      logic         mul_sub;
      a_sel_type    asel;
      b_sel_type    bsel;
      logic         div_start;
      d_sel_type    dsel;
      p_sel_type    psel;
      logic         save_side;
      logic         save_t;
      logic         save_u;
      logic         save_m;
      xr_sel_type   xr_sel;
      yr_sel_type   yr_sel;
      logic         out_ld;
      out_kind_type out_kind;
      logic         upd_prev;
   } cmd_type;

   typedef struct packed {
      logic mul_done;
      logic div_done;
      logic need_cross;
      logic vertical;
      logic ddx_zero;
      logic m_zero;
      logic out_free;
   } status_type;

endpackage

/* design/pls_mac.sv */
// iterative signed multiply-accumulate, one multiplier bit per cycle
// depends on nothing outside this file
module pls_mac #(
   parameter int AW = 100,
   parameter int BW = 33
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 clear,
   input  logic                 sub,
   input  logic signed [AW-1:0] a,
   input  logic signed [BW-1:0] b,
   output logic signed [AW-1:0] acc,
   output logic                 done
);
   localparam int CW = $clog2(BW + 1);

   logic signed [AW-1:0] acc_ff, mcand_ff, sum;
   logic [BW-1:0]        mplier_ff, bmag;
   logic                 neg_ff, busy_ff, done_ff;
   logic [CW-1:0]        cnt_ff;

   assign bmag = b[BW-1] ? -b : b;
   assign sum  = neg_ff ? acc_ff - mcand_ff : acc_ff + mcand_ff;
   assign acc  = acc_ff;
   assign done = done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CW'(BW);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         if (clear) acc_ff <= '0;
         mcand_ff  <= a;
         mplier_ff <= bmag;
         neg_ff    <= sub ^ b[BW-1];
      end else if (busy_ff) begin
         if (mplier_ff[0]) acc_ff <= sum;
         mcand_ff  <= mcand_ff <<< 1;
         mplier_ff <= mplier_ff >> 1;
      end
   end

endmodule

/* design/pls_div.sv */
// restoring signed division truncating toward zero, one quotient bit per cycle,
// followed by an offset add and saturation; depends on nothing outside this file
module pls_div #(
   parameter int AW = 100,
   parameter int W  = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic signed [AW-1:0] num,
   input  logic signed [AW-1:0] den,
   input  logic signed [W-1:0]  post,
   output logic signed [W-1:0]  res,
   output logic                 done
);
   localparam int CW = $clog2(AW + 1);

   logic [AW-1:0]         nmag_ff, dmag_ff, rem_ff, q_ff;
   logic [AW:0]           rem_sh, diff;
   logic                  neg_ff, busy_ff, done_ff, ge;
   logic [CW-1:0]         cnt_ff;
   logic signed [AW+1:0]  qext, qs, total, smax, smin;

   assign rem_sh = {rem_ff, nmag_ff[AW-1]};
   assign diff   = rem_sh - {1'b0, dmag_ff};
   assign ge     = rem_sh >= {1'b0, dmag_ff};

   assign qext  = {2'b00, q_ff};
   assign qs    = neg_ff ? -qext : qext;
   assign total = qs + {{(AW+2-W){post[W-1]}}, post};
   assign smax  = {{(AW+3-W){1'b0}}, {(W-1){1'b1}}};
   assign smin  = ~smax;

   always_comb begin
      if (total > smax)      res = smax[W-1:0];
      else if (total < smin) res = smin[W-1:0];
      else                   res = total[W-1:0];
   end

   assign done = done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CW'(AW);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         nmag_ff <= num[AW-1] ? -num : num;
         dmag_ff <= den[AW-1] ? -den : den;
         neg_ff  <= num[AW-1] ^ den[AW-1];
         rem_ff  <= '0;
         q_ff    <= '0;
      end else if (busy_ff) begin
         nmag_ff <= nmag_ff << 1;
         rem_ff  <= ge ? diff[AW-1:0] : rem_sh[AW-1:0];
         q_ff    <= {q_ff[AW-2:0], ge};
      end
   end

endmodule

/* design/pls_datapath.sv */
// datapath: line and vertex registers, operand selection, the shared
// multiply-accumulate and divide units, and the result register; uses pls_pkg
module pls_datapath #(
   parameter int COORD_WIDTH = pls_pkg::COORD_WIDTH_DEF,
   parameter int IN_DW       = 64,
   parameter int OUT_DW      = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [pls_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [COORD_WIDTH-1:0]        csr_wdata,
   input  logic [IN_DW-1:0]              req_tdata,
   input  logic                          req_tuser,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [OUT_DW-1:0]             rsp_tdata,
   output logic                          rsp_tlast,
   output logic [1:0]                    rsp_tuser,
   input  pls_pkg::cmd_type              cmd,
   output pls_pkg::status_type           st
);
   localparam int W  = COORD_WIDTH;
   localparam int BW = W + 1;
   localparam int AW = 3 * W + 4;

   logic signed [W-1:0]  ax_ff, ay_ff, bx_ff, by_ff;
   logic signed [W-1:0]  vx_ff, vy_ff, cx_ff, cy_ff, xr_ff, yr_ff;
   logic                 start_ff, side_ff, prev_side_ff;
   logic signed [AW-1:0] t_ff, u_ff, m_ff;
   logic signed [W-1:0]  out_x_ff, out_y_ff;
   logic                 out_up_ff, out_cr_ff, out_last_ff, out_valid_ff;

   logic signed [BW-1:0] abx, aby, ddx, ddy, vx_ax, vy_ay, ax_cx, x_ax;
   logic signed [AW-1:0] a_op, d_op, acc;
   logic signed [BW-1:0] b_op;
   logic signed [W-1:0]  p_op, div_res;
   logic                 mul_done, div_done;

   assign abx   = {bx_ff[W-1], bx_ff} - {ax_ff[W-1], ax_ff};
   assign aby   = {by_ff[W-1], by_ff} - {ay_ff[W-1], ay_ff};
   assign ddx   = {vx_ff[W-1], vx_ff} - {cx_ff[W-1], cx_ff};
   assign ddy   = {vy_ff[W-1], vy_ff} - {cy_ff[W-1], cy_ff};
   assign vx_ax = {vx_ff[W-1], vx_ff} - {ax_ff[W-1], ax_ff};
   assign vy_ay = {vy_ff[W-1], vy_ff} - {ay_ff[W-1], ay_ff};
   assign ax_cx = {ax_ff[W-1], ax_ff} - {cx_ff[W-1], cx_ff};
   assign x_ax  = {xr_ff[W-1], xr_ff} - {ax_ff[W-1], ax_ff};

   always_comb begin
      unique case (cmd.asel)
         pls_pkg::A_ABX: a_op = {{(AW-BW){abx[BW-1]}}, abx};
         pls_pkg::A_ABY: a_op = {{(AW-BW){aby[BW-1]}}, aby};
         pls_pkg::A_DDY: a_op = {{(AW-BW){ddy[BW-1]}}, ddy};
         pls_pkg::A_T:   a_op = t_ff;
         pls_pkg::A_U:   a_op = u_ff;
         default:        a_op = '0;
      endcase
   end

   always_comb begin
      unique case (cmd.bsel)
         pls_pkg::B_VY_AY: b_op = vy_ay;
         pls_pkg::B_VX_AX: b_op = vx_ax;
         pls_pkg::B_AX_CX: b_op = ax_cx;
         pls_pkg::B_AX:    b_op = {ax_ff[W-1], ax_ff};
         pls_pkg::B_AY:    b_op = {ay_ff[W-1], ay_ff};
         pls_pkg::B_CY:    b_op = {cy_ff[W-1], cy_ff};
         pls_pkg::B_ABX:   b_op = abx;
         pls_pkg::B_DDX:   b_op = ddx;
         pls_pkg::B_CX:    b_op = {cx_ff[W-1], cx_ff};
         pls_pkg::B_X_AX:  b_op = x_ax;
         default:          b_op = '0;
      endcase
   end

   always_comb begin
      unique case (cmd.dsel)
         pls_pkg::D_DDX: d_op = {{(AW-BW){ddx[BW-1]}}, ddx};
         pls_pkg::D_M:   d_op = m_ff;
         pls_pkg::D_ABX: d_op = {{(AW-BW){abx[BW-1]}}, abx};
         default:        d_op = '0;
      endcase
   end

   always_comb begin
      unique case (cmd.psel)
         pls_pkg::P_ZERO: p_op = '0;
         pls_pkg::P_CY:   p_op = cy_ff;
         pls_pkg::P_AY:   p_op = ay_ff;
         default:         p_op = '0;
      endcase
   end

   pls_mac #(.AW(AW), .BW(BW)) u_mac (
      .clock (clock),
      .reset (reset),
      .start (cmd.mul_start),
      .clear (cmd.mul_clear),
      .sub   (cmd.mul_sub),
      .a     (a_op),
      .b     (b_op),
      .acc   (acc),
      .done  (mul_done)
   );

   pls_div #(.AW(AW), .W(W)) u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (acc),
      .den   (d_op),
      .post  (p_op),
      .res   (div_res),
      .done  (div_done)
   );

   assign st.mul_done   = mul_done;
   assign st.div_done   = div_done;
   assign st.need_cross = !start_ff && (side_ff != prev_side_ff);
   assign st.vertical   = (ax_ff == bx_ff);
   assign st.ddx_zero   = (vx_ff == cx_ff);
   assign st.m_zero     = (m_ff == '0);
   assign st.out_free   = !out_valid_ff || rsp_tready;

   // line registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ax_ff <= '0;
         ay_ff <= '0;
         bx_ff <= W'(65536);
         by_ff <= '0;
      end else if (csr_we) begin
         unique case (pls_pkg::csr_idx_type'(csr_addr))
            pls_pkg::CSR_LINE_AX: ax_ff <= csr_wdata;
            pls_pkg::CSR_LINE_AY: ay_ff <= csr_wdata;
            pls_pkg::CSR_LINE_BX: bx_ff <= csr_wdata;
            pls_pkg::CSR_LINE_BY: by_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // previous vertex state and output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff        <= '0;
         cy_ff        <= '0;
         prev_side_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (cmd.upd_prev) begin
            cx_ff        <= vx_ff;
            cy_ff        <= vy_ff;
            prev_side_ff <= side_ff;
         end
         if (cmd.out_ld)      out_valid_ff <= 1'b1;
         else if (rsp_tready) out_valid_ff <= 1'b0;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      if (cmd.ld_in) begin
         vx_ff    <= req_tdata[W-1:0];
         vy_ff    <= req_tdata[2*W-1:W];
         start_ff <= req_tuser;
      end
      if (cmd.save_side) side_ff <= (acc > 0);
      if (cmd.save_t) t_ff <= acc;
      if (cmd.save_u) u_ff <= acc;
      if (cmd.save_m) m_ff <= acc;
      unique case (cmd.xr_sel)
         pls_pkg::XR_AX:  xr_ff <= ax_ff;
         pls_pkg::XR_CX:  xr_ff <= cx_ff;
         pls_pkg::XR_DIV: xr_ff <= div_res;
         default: ;
      endcase
      unique case (cmd.yr_sel)
         pls_pkg::YR_CY:  yr_ff <= cy_ff;
         pls_pkg::YR_DIV: yr_ff <= div_res;
         default: ;
      endcase
      if (cmd.out_ld) begin
         unique case (cmd.out_kind)
            pls_pkg::OK_UPPER: begin
               out_x_ff    <= xr_ff;
               out_y_ff    <= yr_ff;
               out_up_ff   <= 1'b1;
               out_cr_ff   <= 1'b1;
               out_last_ff <= 1'b0;
            end
            pls_pkg::OK_LOWER: begin
               out_x_ff    <= xr_ff;
               out_y_ff    <= yr_ff;
               out_up_ff   <= 1'b0;
               out_cr_ff   <= 1'b1;
               out_last_ff <= 1'b0;
            end
            default: begin
               out_x_ff    <= vx_ff;
               out_y_ff    <= vy_ff;
               out_up_ff   <= side_ff;
               out_cr_ff   <= 1'b0;
               out_last_ff <= 1'b1;
            end
         endcase
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = OUT_DW'({out_y_ff, out_x_ff});
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = {out_cr_ff, out_up_ff};

endmodule

/* design/pls_ctrl.sv */
// controller: sequences multiply, divide and emit steps for one vertex
// uses pls_pkg for states, commands and status
module pls_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  pls_pkg::status_type st,
   output pls_pkg::cmd_type    cmd
);
   pls_pkg::state_type state_ff, state_in, go_next;
   logic               launched_ff, launched_in, op_mul, op_div;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= pls_pkg::ST_IDLE;
         launched_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         launched_ff <= launched_in;
      end
   end

   always_comb begin
      cmd         = '0;
      state_in    = state_ff;
      launched_in = launched_ff;
      go_next     = state_ff;
      op_mul      = 1'b0;
      op_div      = 1'b0;
      req_tready  = 1'b0;

      unique case (state_ff)
         pls_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.ld_in  = req_tvalid;
            if (req_tvalid) state_in = pls_pkg::ST_SIDE_A;
         end
         pls_pkg::ST_SIDE_A: begin
            op_mul = 1'b1; cmd.mul_clear = 1'b1;
            cmd.asel = pls_pkg::A_ABX; cmd.bsel = pls_pkg::B_VY_AY;
            go_next = pls_pkg::ST_SIDE_B;
         end
         pls_pkg::ST_SIDE_B: begin
            op_mul = 1'b1; cmd.mul_sub = 1'b1;
            cmd.asel = pls_pkg::A_ABY; cmd.bsel = pls_pkg::B_VX_AX;
            cmd.save_side = st.mul_done;
            go_next = pls_pkg::ST_DECIDE;
         end
         pls_pkg::ST_DECIDE: begin
            priority if (!st.need_cross) begin
               state_in = pls_pkg::ST_EMIT_V;
            end else if (st.vertical && st.ddx_zero) begin
               cmd.xr_sel = pls_pkg::XR_AX;
               cmd.yr_sel = pls_pkg::YR_CY;
               state_in   = pls_pkg::ST_EMIT_U;
            end else if (st.vertical) begin
               state_in = pls_pkg::ST_V_MUL;
            end else begin
               state_in = pls_pkg::ST_P0;
            end
         end
         pls_pkg::ST_V_MUL: begin
            op_mul = 1'b1; cmd.mul_clear = 1'b1;
            cmd.asel = pls_pkg::A_DDY; cmd.bsel = pls_pkg::B_AX_CX;
            go_next = pls_pkg::ST_V_DIV;
         end
         pls_pkg::ST_V_DIV: begin
            op_div = 1'b1;
            cmd.dsel = pls_pkg::D_DDX; cmd.psel = pls_pkg::P_CY;
            if (st.div_done) begin
               cmd.xr_sel = pls_pkg::XR_AX;
               cmd.yr_sel = pls_pkg::YR_DIV;
            end
            go_next = pls_pkg::ST_EMIT_U;
         end
         pls_pkg::ST_P0: begin
            op_mul = 1'b1; cmd.mul_clear = 1'b1;
            cmd.asel = pls_pkg::A_ABY; cmd.bsel = pls_pkg::B_AX;
            go_next = pls_pkg::ST_P1;
         end
         pls_pkg::ST_P1: begin
            op_mul = 1'b1; cmd.mul_sub = 1'b1;
            cmd.asel = pls_pkg::A_ABX; cmd.bsel = pls_pkg::B_AY;
            go_next = pls_pkg::ST_P2;
         end
         pls_pkg::ST_P2: begin
            op_mul = 1'b1;
            cmd.asel = pls_pkg::A_ABX; cmd.bsel = pls_pkg::B_CY;
            cmd.save_t = st.mul_done;
            go_next = pls_pkg::ST_U;
         end
         pls_pkg::ST_U: begin
            op_mul = 1'b1; cmd.mul_clear = 1'b1;
            cmd.asel = pls_pkg::A_DDY; cmd.bsel = pls_pkg::B_ABX;
            cmd.save_u = st.mul_done;
            go_next = pls_pkg::ST_M0;
         end
         pls_pkg::ST_M0: begin
            op_mul = 1'b1; cmd.mul_clear = 1'b1;
            cmd.asel = pls_pkg::A_ABY; cmd.bsel = pls_pkg::B_DDX;
            go_next = pls_pkg::ST_M1;
         end
         pls_pkg::ST_M1: begin
            op_mul = 1'b1; cmd.mul_sub = 1'b1;
            cmd.asel = pls_pkg::A_DDY; cmd.bsel = pls_pkg::B_ABX;
            cmd.save_m = st.mul_done;
            go_next = pls_pkg::ST_N0;
         end
         pls_pkg::ST_N0: begin
            if (!launched_ff && st.m_zero) begin
               // parallel segment: crossing x falls back to the previous vertex
               cmd.xr_sel = pls_pkg::XR_CX;
               state_in   = pls_pkg::ST_Y_MUL;
            end else begin
               op_mul = 1'b1; cmd.mul_clear = 1'b1;
               cmd.asel = pls_pkg::A_T; cmd.bsel = pls_pkg::B_DDX;
               go_next = pls_pkg::ST_N1;
            end
         end
         pls_pkg::ST_N1: begin
            op_mul = 1'b1; cmd.mul_sub = 1'b1;
            cmd.asel = pls_pkg::A_U; cmd.bsel = pls_pkg::B_CX;
            go_next = pls_pkg::ST_X_DIV;
         end
         pls_pkg::ST_X_DIV: begin
            op_div = 1'b1;
            cmd.dsel = pls_pkg::D_M; cmd.psel = pls_pkg::P_ZERO;
            if (st.div_done) cmd.xr_sel = pls_pkg::XR_DIV;
            go_next = pls_pkg::ST_Y_MUL;
         end
         pls_pkg::ST_Y_MUL: begin
            op_mul = 1'b1; cmd.mul_clear = 1'b1;
            cmd.asel = pls_pkg::A_ABY; cmd.bsel = pls_pkg::B_X_AX;
            go_next = pls_pkg::ST_Y_DIV;
         end
         pls_pkg::ST_Y_DIV: begin
            op_div = 1'b1;
            cmd.dsel = pls_pkg::D_ABX; cmd.psel = pls_pkg::P_AY;
            if (st.div_done) cmd.yr_sel = pls_pkg::YR_DIV;
            go_next = pls_pkg::ST_EMIT_U;
         end
         pls_pkg::ST_EMIT_U: begin
            cmd.out_kind = pls_pkg::OK_UPPER;
            if (st.out_free) begin
               cmd.out_ld = 1'b1;
               state_in   = pls_pkg::ST_EMIT_L;
            end
         end
         pls_pkg::ST_EMIT_L: begin
            cmd.out_kind = pls_pkg::OK_LOWER;
            if (st.out_free) begin
               cmd.out_ld = 1'b1;
               state_in   = pls_pkg::ST_EMIT_V;
            end
         end
         pls_pkg::ST_EMIT_V: begin
            cmd.out_kind = pls_pkg::OK_VERTEX;
            if (st.out_free) begin
               cmd.out_ld   = 1'b1;
               cmd.upd_prev = 1'b1;
               state_in     = pls_pkg::ST_IDLE;
            end
         end
         default: state_in = pls_pkg::ST_IDLE;
      endcase

      // launch the unit once, then wait for its done pulse
      if (op_mul) begin
         if (!launched_ff) begin
            cmd.mul_start = 1'b1;
            launched_in   = 1'b1;
         end else if (st.mul_done) begin
            launched_in = 1'b0;
            state_in    = go_next;
         end
      end
      if (op_div) begin
         if (!launched_ff) begin
            cmd.div_start = 1'b1;
            launched_in   = 1'b1;
         end else if (st.div_done) begin
            launched_in = 1'b0;
            state_in    = go_next;
         end
      end
   end

endmodule

/* design/polygon_line_splitter.sv */
// polygon line splitter, top level: controller plus datapath, one vertex at a time
// no crossing: the side test leads straight to the vertex result
// with crossing: the crossing point is worked out with the bit-serial multiply-accumulate
// and the one-bit-per-cycle divider before the upper, lower and vertex results
// next vertex is taken once the vertex result is loaded into the output register
// synchronous active-high reset: line A=(0,0), B=(1.0,0), previous vertex (0,0) lower, output empty
module polygon_line_splitter #(
   parameter int COORD_WIDTH = pls_pkg::COORD_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   // configuration writes
   input  logic                           csr_we,
   input  logic [pls_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [COORD_WIDTH-1:0]         csr_wdata,
   // vertex input
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [((2*COORD_WIDTH+7)/8)*8-1:0] req_tdata,  // vertex_x, vertex_y
   input  logic                           req_tuser,      // ring_start
   // point output
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [((2*COORD_WIDTH+7)/8)*8-1:0] rsp_tdata,  // out_x, out_y
   output logic                           rsp_tlast,      // last_of_run
   output logic [1:0]                     rsp_tuser       // upper_side, is_crossing
);
   localparam int DW = ((2 * COORD_WIDTH + 7) / 8) * 8;

   pls_pkg::cmd_type    cmd;
   pls_pkg::status_type st;

   // sequencer: side test, crossing math, then up to three result transactions
   pls_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .st         (st),
      .cmd        (cmd)
   );

   // registers, shared multiply-accumulate, divider and output stage
   pls_datapath #(
      .COORD_WIDTH (COORD_WIDTH),
      .IN_DW       (DW),
      .OUT_DW      (DW)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .cmd        (cmd),
      .st         (st)
   );

endmodule
